// ----- src/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and helpers for the longest prefix route table
// Operation and status codes, the request, token and write bus structs,
// and the prefix mask function used by every cell.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int ADDR_W          = 32;
    localparam int LEN_W           = 6;
    localparam int PORT_W          = 16;
    localparam int ROUTE_ENTRIES_D = 32;
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } lpr_req_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              dup;
        logic              free_found;
        logic [LEN_W-1:0]  best_len;
        logic [PORT_W-1:0] best_port;
        logic [ADDR_W-1:0] best_hop;
    } lpr_tok_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] hop;
    } lpr_wr_t;

    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]  sat;
        logic [ADDR_W-1:0] m;
        begin
            sat = (len > MAX_LEN) ? MAX_LEN : len;
            m   = '0;
            if (sat != '0)
            begin
                m = {ADDR_W{1'b1}} << (MAX_LEN - sat);
            end
            return m;
        end
    endfunction

endpackage

// ----- src/lpr_cell.sv -----
// ----------------------------------------------------------------------------
// lpr_cell: one route table slot
// Holds one entry, compares it against the request broadcast by the top
// level and updates the result token passed on to the next cell.
// ----------------------------------------------------------------------------
module lpr_cell
    import lpr_pkg::*;
#(
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lpr_req_t         req,
    input  lpr_tok_t         tok_in,
    input  logic [IDX_W-1:0] idx_in,
    input  lpr_wr_t          wr,
    input  logic [IDX_W-1:0] wr_idx,
    output lpr_tok_t         tok_out,
    output logic [IDX_W-1:0] idx_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [ADDR_W-1:0] prefix_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [PORT_W-1:0] port_reg;
    logic [ADDR_W-1:0] hop_reg;
    lpr_tok_t          tok_reg;
    lpr_tok_t          tok_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              lookup_match;
    logic              key_match;
    logic              wr_hit;

    assign lookup_match = valid_reg &&
        (((req.addr ^ prefix_reg) & len_mask(len_reg)) == '0);
    assign key_match    = valid_reg && (len_reg == req.len) &&
        (((req.addr ^ prefix_reg) & len_mask(req.len)) == '0);
    assign wr_hit       = wr.en && (wr_idx == IDX_W'(CELL_IDX));

    always_comb
    begin
        tok_next   = tok_in;
        idx_next   = idx_in;
        valid_next = valid_reg;
        if (tok_in.valid)
        begin
            case (req.kind)
                KIND_LOOKUP:
                begin
                    if (lookup_match && (!tok_in.hit || len_reg > tok_in.best_len))
                    begin
                        tok_next.hit       = 1'b1;
                        tok_next.best_len  = len_reg;
                        tok_next.best_port = port_reg;
                        tok_next.best_hop  = hop_reg;
                    end
                end
                KIND_INSERT:
                begin
                    if (key_match)
                    begin
                        tok_next.dup = 1'b1;
                    end
                    if (!valid_reg && !tok_in.free_found)
                    begin
                        tok_next.free_found = 1'b1;
                        idx_next            = IDX_W'(CELL_IDX);
                    end
                end
                KIND_DELETE:
                begin
                    if (key_match && !tok_in.hit)
                    begin
                        tok_next.hit = 1'b1;
                        valid_next   = 1'b0;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
        if (wr_hit)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            prefix_reg <= wr.prefix;
            len_reg    <= wr.len;
            port_reg   <= wr.port;
            hop_reg    <= wr.hop;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

// ----- src/longest_prefix_route_table.sv -----
// Flow: one transaction at a time; a new input is taken only in the idle state.
// The result token walks the chain of slot cells one cell per cycle; the
// sequencer then registers the decided result, moves it into the output
// register once that register is free, and returns to idle for the next input.
// A finished result waits in the output register while the next one is taken.
// Reset: asynchronous, active low; clears every slot valid bit and control.
// ----------------------------------------------------------------------------
// longest_prefix_route_table: IPv4 longest prefix match route table
// Lookup, insert and delete over a chain of slot cells with a sequencer.
// ----------------------------------------------------------------------------
module longest_prefix_route_table
    import lpr_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_D
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [ADDR_W-1:0] addr,
    input  logic [LEN_W-1:0]  prefix_len,
    input  logic [PORT_W-1:0] if_index,
    input  logic [ADDR_W-1:0] next_hop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] hop_out,
    output logic [PORT_W-1:0] port_out
);

    localparam int IDX_W = $clog2(ROUTE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               start_reg;
    lpr_req_t           req_reg;
    logic [PORT_W-1:0]  req_port_reg;
    logic [ADDR_W-1:0]  req_hop_reg;
    logic [1:0]         res_status_reg;
    logic [ADDR_W-1:0]  res_hop_reg;
    logic [PORT_W-1:0]  res_port_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [ADDR_W-1:0]  hop_out_reg;
    logic [PORT_W-1:0]  port_out_reg;

    lpr_tok_t           tok_chain [ROUTE_ENTRIES];
    logic [IDX_W-1:0]   idx_chain [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] tok_valid_vec;
    lpr_tok_t           inj_tok;
    lpr_tok_t           tail_tok;
    logic [IDX_W-1:0]   tail_idx;
    lpr_wr_t            wr;
    logic [1:0]         res_status;
    logic [ADDR_W-1:0]  res_hop;
    logic [PORT_W-1:0]  res_port;
    logic               in_acc;
    logic               tail_done;
    logic               emit_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign tail_tok  = tok_chain[ROUTE_ENTRIES-1];
    assign tail_idx  = idx_chain[ROUTE_ENTRIES-1];
    assign tail_done = (state_reg == S_SWEEP) && tail_tok.valid;
    assign emit_go   = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        inj_tok       = '0;
        inj_tok.valid = start_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ROUTE_ENTRIES; gi++)
        begin : g_cell
            lpr_tok_t         cell_tok_in;
            logic [IDX_W-1:0] cell_idx_in;
            if (gi == 0)
            begin : g_head
                assign cell_tok_in = inj_tok;
                assign cell_idx_in = '0;
            end
            else
            begin : g_link
                assign cell_tok_in = tok_chain[gi-1];
                assign cell_idx_in = idx_chain[gi-1];
            end
            lpr_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .req     (req_reg),
                .tok_in  (cell_tok_in),
                .idx_in  (cell_idx_in),
                .wr      (wr),
                .wr_idx  (tail_idx),
                .tok_out (tok_chain[gi]),
                .idx_out (idx_chain[gi])
            );
            assign tok_valid_vec[gi] = tok_chain[gi].valid;
        end
    endgenerate

    always_comb
    begin
        wr        = '0;
        wr.prefix = req_reg.addr;
        wr.len    = req_reg.len;
        wr.port   = req_port_reg;
        wr.hop    = req_hop_reg;
        wr.en     = tail_done && (req_reg.kind == KIND_INSERT) &&
                    !tail_tok.dup && tail_tok.free_found;
    end

    always_comb
    begin
        res_status = ST_MISS;
        res_hop    = '0;
        res_port   = '0;
        case (req_reg.kind)
            KIND_LOOKUP:
            begin
                if (tail_tok.hit)
                begin
                    res_status = ST_OK;
                    res_hop    = tail_tok.best_hop;
                    res_port   = tail_tok.best_port;
                end
            end
            KIND_INSERT:
            begin
                if (tail_tok.dup)
                begin
                    res_status = ST_DUP;
                end
                else if (!tail_tok.free_found)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_status = ST_OK;
                end
            end
            KIND_DELETE:
            begin
                if (tail_tok.hit)
                begin
                    res_status = ST_OK;
                end
            end
            default:
            begin
                res_status = ST_MISS;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (tail_tok.valid)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_acc;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg.kind <= kind;
            req_reg.addr <= addr;
            req_reg.len  <= (prefix_len > MAX_LEN) ? MAX_LEN : prefix_len;
            req_port_reg <= if_index;
            req_hop_reg  <= next_hop;
        end
        if (tail_done)
        begin
            res_status_reg <= res_status;
            res_hop_reg    <= res_hop;
            res_port_reg   <= res_port;
        end
        if (emit_go)
        begin
            status_reg   <= res_status_reg;
            hop_out_reg  <= res_hop_reg;
            port_out_reg <= res_port_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign hop_out   = hop_out_reg;
    assign port_out  = port_out_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid_vec) <= 1)
        else $error("more than one token in the cell chain");

    a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        tail_tok.valid |-> state_reg == S_SWEEP)
        else $error("token left the chain outside the sweep");

    a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (tail_tok.valid && !tail_tok.dup && tail_tok.free_found))
        else $error("insert write without a free slot or with a duplicate");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result presented without passing the emit state");

endmodule

// ----- verif/longest_prefix_route_table_tb.sv -----
// ----------------------------------------------------------------------------
// longest_prefix_route_table_tb: self-checking bench for the route table
// Drives lookup, insert and delete transactions through the valid/ready
// input channel. A shadow copy of the route slots predicts every result.
// Results are compared in order, field by field. A directed opening hits
// default routes, nested prefixes, duplicates, length saturation, slot reuse
// and the unused operation code. Random blocks then each pick a filling, a
// draining or a mixed operation profile. Both channels idle at random outside
// a quiet stretch, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module longest_prefix_route_table_tb;
    import lpr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_OPS   = 1530;
    localparam int BLOCK_OPS    = 100;
    localparam int POOL_DEPTH   = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 2 * ROUTE_ENTRIES_D + 8;
    localparam int RUN_LIMIT    = 1600000;

    typedef struct packed {
        status_t           st;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } route_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  prefix_len;
    logic [PORT_W-1:0] if_index;
    logic [ADDR_W-1:0] next_hop;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] hop_out;
    logic [PORT_W-1:0] port_out;

    bit                src_idle_en;
    bit                snk_idle_en;
    int                ops_accepted;
    logic [ADDR_W-1:0] pool_addr[$];
    logic [LEN_W-1:0]  pool_len[$];

    function automatic logic [ADDR_W-1:0] top_mask(input logic [LEN_W-1:0] l);
        if (l == '0)
        begin
            return '0;
        end
        return {ADDR_W{1'b1}} << (32 - l);
    endfunction

    class route_checker;
        bit                slot_used[ROUTE_ENTRIES_D];
        logic [ADDR_W-1:0] slot_prefix[ROUTE_ENTRIES_D];
        logic [LEN_W-1:0]  slot_len[ROUTE_ENTRIES_D];
        logic [PORT_W-1:0] slot_port[ROUTE_ENTRIES_D];
        logic [ADDR_W-1:0] slot_hop[ROUTE_ENTRIES_D];
        route_result_t     pending_results[$];
        int                errors;
        int                n_lookup;
        int                n_hit;
        int                n_insert;
        int                n_full;
        int                n_dup;
        int                n_delete;
        int                n_removed;
        int                n_unused;

        function void note_op(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                              input logic [LEN_W-1:0] plen,
                              input logic [PORT_W-1:0] ifx,
                              input logic [ADDR_W-1:0] nh);
            route_result_t r;
            logic [LEN_W-1:0] l;
            int best;
            int free_slot;
            bit dup;
            r = '{st: ST_MISS, hop: '0, port: '0};
            l = (plen > 6'd32) ? 6'd32 : plen;
            best = -1;
            free_slot = -1;
            dup = 1'b0;
            case (op)
                KIND_LOOKUP:
                begin
                    n_lookup++;
                    for (int i = 0; i < ROUTE_ENTRIES_D; i++)
                    begin
                        if (slot_used[i] &&
                            (((a ^ slot_prefix[i]) & top_mask(slot_len[i])) == '0) &&
                            (best < 0 || slot_len[i] > slot_len[best]))
                        begin
                            best = i;
                        end
                    end
                    if (best >= 0)
                    begin
                        n_hit++;
                        r = '{st: ST_OK, hop: slot_hop[best], port: slot_port[best]};
                    end
                end
                KIND_INSERT:
                begin
                    n_insert++;
                    for (int i = 0; i < ROUTE_ENTRIES_D; i++)
                    begin
                        if (slot_used[i])
                        begin
                            if (slot_len[i] == l &&
                                (((a ^ slot_prefix[i]) & top_mask(l)) == '0))
                            begin
                                dup = 1'b1;
                            end
                        end
                        else if (free_slot < 0)
                        begin
                            free_slot = i;
                        end
                    end
                    if (dup)
                    begin
                        n_dup++;
                        r.st = ST_DUP;
                    end
                    else if (free_slot < 0)
                    begin
                        n_full++;
                        r.st = ST_FULL;
                    end
                    else
                    begin
                        slot_used[free_slot]   = 1'b1;
                        slot_prefix[free_slot] = a;
                        slot_len[free_slot]    = l;
                        slot_port[free_slot]   = ifx;
                        slot_hop[free_slot]    = nh;
                        r.st = ST_OK;
                    end
                end
                KIND_DELETE:
                begin
                    n_delete++;
                    for (int i = 0; i < ROUTE_ENTRIES_D; i++)
                    begin
                        if (slot_used[i] && slot_len[i] == l &&
                            (((a ^ slot_prefix[i]) & top_mask(l)) == '0))
                        begin
                            slot_used[i] = 1'b0;
                            n_removed++;
                            r.st = ST_OK;
                            break;
                        end
                    end
                end
                default:
                begin
                    n_unused++;
                end
            endcase
            pending_results.push_back(r);
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 50)
            begin
                $display("[%0t] %s", $time, msg);
            end
        endtask

        task check_result(input logic [1:0] st, input logic [ADDR_W-1:0] h,
                          input logic [PORT_W-1:0] p);
            route_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result: status %0d hop %h port %h", st, h, p));
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.st)
            begin
                report($sformatf("status: got %0d, want %0d", st, want.st));
            end
            if (h !== want.hop)
            begin
                report($sformatf("hop_out: got %h, want %h", h, want.hop));
            end
            if (p !== want.port)
            begin
                report($sformatf("port_out: got %h, want %h", p, want.port));
            end
        endtask
    endclass

    route_checker sb;

    longest_prefix_route_table u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .addr       (addr),
        .prefix_len (prefix_len),
        .if_index   (if_index),
        .next_hop   (next_hop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .hop_out    (hop_out),
        .port_out   (port_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_op(input logic [1:0] k, input logic [ADDR_W-1:0] a,
                           input logic [LEN_W-1:0] l, input logic [PORT_W-1:0] ix,
                           input logic [ADDR_W-1:0] nh);
        while (src_idle_en && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        addr       <= a;
        prefix_len <= l;
        if_index   <= ix;
        next_hop   <= nh;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_op(k, a, l, ix, nh);
        ops_accepted++;
        @(negedge clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            return '0;
        end
        if (r < 8)
        begin
            return LEN_W'($urandom_range(33, 63));
        end
        if (r < 20)
        begin
            return 6'd32;
        end
        if (r < 45)
        begin
            return LEN_W'(8 * $urandom_range(1, 3));
        end
        return LEN_W'($urandom_range(1, 31));
    endfunction

    function automatic logic [ADDR_W-1:0] keep_top(input logic [ADDR_W-1:0] a,
                                                   input logic [LEN_W-1:0] l);
        return (a & top_mask(l)) | (ADDR_W'($urandom) & ~top_mask(l));
    endfunction

    task automatic random_op(input int mode);
        int r;
        int pick;
        int ins_pct;
        int del_pct;
        logic [1:0]        k;
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  l;
        ins_pct = (mode == 0) ? 65 : (mode == 1) ? 15 : 35;
        del_pct = (mode == 0) ? 10 : (mode == 1) ? 45 : 25;
        r    = $urandom_range(0, 99);
        pick = (pool_addr.size() > 0) ? $urandom_range(0, pool_addr.size() - 1) : -1;
        l    = pick_len();
        a    = $urandom;
        if (r < 4)
        begin
            k = KIND_UNUSED;
        end
        else if (r < 4 + ins_pct)
        begin
            k = KIND_INSERT;
            if (pick >= 0 && $urandom_range(0, 99) < 15)
            begin
                l = pool_len[pick];
                a = keep_top(pool_addr[pick], l);
            end
            else
            begin
                if (pick >= 0 && pool_len[pick] < 6'd32 && $urandom_range(0, 99) < 40)
                begin
                    l = LEN_W'($urandom_range(pool_len[pick] + 1, 32));
                    a = keep_top(pool_addr[pick], pool_len[pick]);
                end
                if (pool_addr.size() >= POOL_DEPTH)
                begin
                    pick = $urandom_range(0, POOL_DEPTH - 1);
                    pool_addr.delete(pick);
                    pool_len.delete(pick);
                end
                pool_addr.push_back(a);
                pool_len.push_back((l > 6'd32) ? 6'd32 : l);
            end
        end
        else if (r < 4 + ins_pct + del_pct)
        begin
            k = KIND_DELETE;
            if (pick >= 0 && $urandom_range(0, 99) < 75)
            begin
                l = pool_len[pick];
                a = keep_top(pool_addr[pick], l);
                if (l == 6'd32 && $urandom_range(0, 3) == 0)
                begin
                    l = LEN_W'($urandom_range(33, 63));
                end
            end
        end
        else
        begin
            k = KIND_LOOKUP;
            if (pick >= 0 && $urandom_range(0, 99) < 75)
            begin
                a = keep_top(pool_addr[pick], pool_len[pick]);
            end
        end
        send_op(k, a, l, PORT_W'($urandom), ADDR_W'($urandom));
    endtask

    // receiver: random stalls plus one long hold-off to back the block up
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && ops_accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !(snk_idle_en && $urandom_range(0, 99) < 33);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(status, hop_out, port_out);
        end
    end

    initial
    begin
        int blk_mode;
        bit quiet;
        blk_mode     = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_LOOKUP;
        addr         = '0;
        prefix_len   = '0;
        if_index     = '0;
        next_hop     = '0;
        ops_accepted = 0;
        src_idle_en  = 1'b1;
        snk_idle_en  = 1'b1;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_op(KIND_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_DELETE, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 32'h1234_5678, 6'd0,  16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_INSERT, 32'hC0A8_0000, 6'd16, 16'h0001, 32'h0A00_0001);
        send_op(KIND_INSERT, 32'hC0A8_01FF, 6'd24, 16'h0002, 32'h0A00_0002);
        send_op(KIND_LOOKUP, 32'hC0A8_0105, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_LOOKUP, 32'hC0A8_0205, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_LOOKUP, 32'hC0A9_0000, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_INSERT, 32'hC0A8_FFFF, 6'd16, 16'h0003, 32'h0A00_0003);
        send_op(KIND_INSERT, 32'h0A00_0001, 6'd40, 16'h0000, 32'h0000_0000);
        send_op(KIND_LOOKUP, 32'h0A00_0001, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_INSERT, 32'h0A00_0001, 6'd32, 16'h0004, 32'h0A00_0004);
        send_op(KIND_DELETE, 32'h0A00_0001, 6'd63, 16'h0000, 32'h0000_0000);
        send_op(KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_UNUSED, 32'hC0A8_0105, 6'd24, 16'h1111, 32'h2222_2222);
        send_op(KIND_DELETE, 32'hC0A8_AAAA, 6'd16, 16'h0000, 32'h0000_0000);
        send_op(KIND_DELETE, 32'hC0A8_AAAA, 6'd16, 16'h0000, 32'h0000_0000);
        send_op(KIND_LOOKUP, 32'hC0A8_0205, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_DELETE, 32'h0000_0000, 6'd0,  16'h0000, 32'h0000_0000);
        send_op(KIND_LOOKUP, 32'h8000_0000, 6'd0,  16'h0000, 32'h0000_0000);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % BLOCK_OPS == 0)
            begin
                blk_mode = $urandom_range(0, 2);
            end
            quiet = (n >= 600 && n < 900);
            src_idle_en = !quiet;
            snk_idle_en = !quiet;
            random_op(blk_mode);
        end
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions: %0d lookups (%0d hits), %0d inserts",
                 ops_accepted, sb.n_lookup, sb.n_hit, sb.n_insert);
        $display("  %0d refused full, %0d duplicate, %0d deletes (%0d removed), %0d unused",
                 sb.n_full, sb.n_dup, sb.n_delete, sb.n_removed, sb.n_unused);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
